// ===== sv/assert_macros.svh =====
// Concurrent assertion macros used by the serial port RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GPSP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define GPSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GPSP_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define GPSP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/gpsp_pkg.sv =====
// Types, constants and helper functions for the game pad serial port.
package gpsp_pkg;

   typedef enum logic [1:0] {
      CMD_BUTTON = 2'd0,
      CMD_READ   = 2'd1,
      CMD_STROBE = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef logic [7:0]  pad_byte_type;
   typedef logic [23:0] port_word_type;
   typedef logic [31:0] shift_word_type;

   localparam pad_byte_type  UD_BITS   = 8'h30;
   localparam pad_byte_type  UD_KEEP   = 8'hCF;
   localparam pad_byte_type  LR_BITS   = 8'hC0;
   localparam pad_byte_type  LR_KEEP   = 8'h3F;
   localparam pad_byte_type  SIG_PORT0 = 8'h08;
   localparam pad_byte_type  SIG_PORT1 = 8'h04;
   localparam port_word_type KEEP_HIGH = 24'hFFFF00;
   localparam port_word_type KEEP_LOW  = 24'h0000FF;
   localparam pad_byte_type  READ_BASE = 8'h40;
   localparam pad_byte_type  FILL_BIT  = 8'h80;

   function automatic pad_byte_type filter_pad(input pad_byte_type held);
      pad_byte_type f;
      f = held;
      if ((f & UD_BITS) == UD_BITS) begin
         f = f & UD_KEEP;
      end
      if ((f & LR_BITS) == LR_BITS) begin
         f = f & LR_KEEP;
      end
      return f;
   endfunction

endpackage

// ===== sv/game_pad_serial_port_unit.sv =====
// Game pad serial port: four player masks, two port words and shift registers.
// A port read gives its result on rsp_ in the cycle after it is accepted.
// Throughput: one transaction per cycle unless a held result stalls req_ready; the result register frees on take.
// A button event or strobe write updates state at its accept edge, no result.
// Synchronous active-high reset clears all masks, words, strobe and rsp_valid.
`include "assert_macros.svh"
module game_pad_serial_port_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [1:0] req_player,
   input  logic [7:0] req_button_mask,
   input  logic       req_pressed,
   input  logic       req_port,
   input  logic       req_strobe_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data
);

   gpsp_pkg::pad_byte_type   held_ff [4];
   gpsp_pkg::pad_byte_type   held_in [4];
   gpsp_pkg::pad_byte_type   filt_ff [4];
   gpsp_pkg::pad_byte_type   filt_in [4];
   gpsp_pkg::port_word_type  port_word_ff [2];
   gpsp_pkg::port_word_type  port_word_in [2];
   gpsp_pkg::shift_word_type shift_word_ff [2];
   gpsp_pkg::shift_word_type shift_word_in [2];
   logic                     strobe_high_ff;
   logic                     strobe_high_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [7:0]               read_data_ff;
   logic [7:0]               read_data_in;

   logic                     accept;
   gpsp_pkg::cmd_type        cmd;
   gpsp_pkg::pad_byte_type   new_held;
   gpsp_pkg::pad_byte_type   new_filt;
   gpsp_pkg::pad_byte_type   sig;
   gpsp_pkg::port_word_type  cur_word;

   logic                     read_accept;
   logic                     shift_hold;
   logic [63:0]              shift_pair;
   logic                     p0_sig_ok;
   logic                     p1_sig_ok;
   logic                     filt_ok;

   assign req_ready     = !rsp_valid_ff || rsp_ready;
   assign accept        = req_valid && req_ready;
   assign cmd           = gpsp_pkg::cmd_type'(req_cmd);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = read_data_ff;

   always_comb begin
      held_in        = held_ff;
      filt_in        = filt_ff;
      port_word_in   = port_word_ff;
      shift_word_in  = shift_word_ff;
      strobe_high_in = strobe_high_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      read_data_in   = read_data_ff;
      new_held       = req_pressed ? (held_ff[req_player] | req_button_mask)
                                   : (held_ff[req_player] & ~req_button_mask);
      new_filt       = gpsp_pkg::filter_pad(new_held);
      sig            = req_player[0] ? gpsp_pkg::SIG_PORT1 : gpsp_pkg::SIG_PORT0;
      cur_word       = port_word_ff[req_player[0]];
      if (accept) begin
         unique case (cmd)
            gpsp_pkg::CMD_BUTTON: begin
               held_in[req_player] = new_held;
               filt_in[req_player] = new_filt;
               if (new_filt != filt_ff[req_player]) begin
                  if (!req_player[1]) begin
                     port_word_in[req_player[0]] = (cur_word & gpsp_pkg::KEEP_HIGH)
                        | {sig, 16'h0000} | {16'h0000, new_filt};
                  end else begin
                     port_word_in[req_player[0]] = (cur_word & gpsp_pkg::KEEP_LOW)
                        | {sig, 16'h0000} | {8'h00, new_filt, 8'h00};
                  end
               end
            end
            gpsp_pkg::CMD_READ: begin
               rsp_valid_in = 1'b1;
               if (strobe_high_ff) begin
                  read_data_in = gpsp_pkg::READ_BASE | {7'h00, port_word_ff[req_port][0]};
               end else begin
                  read_data_in = gpsp_pkg::READ_BASE | {7'h00, shift_word_ff[req_port][0]};
                  shift_word_in[req_port] = {gpsp_pkg::FILL_BIT, 24'h000000}
                     | {1'b0, shift_word_ff[req_port][31:1]};
               end
            end
            gpsp_pkg::CMD_STROBE: begin
               if (strobe_high_ff && !req_strobe_level) begin
                  shift_word_in[0] = {8'h00, port_word_ff[0]};
                  shift_word_in[1] = {8'h00, port_word_ff[1]};
               end
               strobe_high_in = req_strobe_level;
            end
            gpsp_pkg::CMD_UNUSED: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff        <= '{default: '0};
         filt_ff        <= '{default: '0};
         port_word_ff   <= '{default: '0};
         shift_word_ff  <= '{default: '0};
         strobe_high_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         held_ff        <= held_in;
         filt_ff        <= filt_in;
         port_word_ff   <= port_word_in;
         shift_word_ff  <= shift_word_in;
         strobe_high_ff <= strobe_high_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= read_data_in;
   end

   assign read_accept = accept && (cmd == gpsp_pkg::CMD_READ);
   assign shift_hold  = strobe_high_ff && !(accept && (cmd == gpsp_pkg::CMD_STROBE));
   assign shift_pair  = {shift_word_ff[1], shift_word_ff[0]};
   assign p0_sig_ok   = (port_word_ff[0][23:16] == 8'h00)
                        || (port_word_ff[0][23:16] == gpsp_pkg::SIG_PORT0);
   assign p1_sig_ok   = (port_word_ff[1][23:16] == 8'h00)
                        || (port_word_ff[1][23:16] == gpsp_pkg::SIG_PORT1);
   assign filt_ok     = (filt_ff[req_player][5:4] != 2'b11)
                        && (filt_ff[req_player][7:6] != 2'b11);

   `GPSP_ASSERT_NEXT(a_read_gives_rsp, clock, reset, read_accept, rsp_valid_ff)
   `GPSP_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, accept && !read_accept, !rsp_valid_ff)
   `GPSP_ASSERT_NOW(a_port0_sig, clock, reset, 1'b1, p0_sig_ok)
   `GPSP_ASSERT_NOW(a_port1_sig, clock, reset, 1'b1, p1_sig_ok)
   `GPSP_ASSERT_NEXT(a_shift_hold_strobe, clock, reset, shift_hold, $stable(shift_pair))
   `GPSP_ASSERT_NOW(a_filter_ud, clock, reset, 1'b1, filt_ok)

endmodule

// ===== tb/game_pad_serial_port_unit_tb.sv =====
// Self-checking testbench for the game pad serial port: directed table, random sequences.
module game_pad_serial_port_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS_PER_PHASE = 180;
   localparam int HOLD_CYCLES     = 80;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DIRECTED_ROWS   = 24;

   typedef struct packed {
      gpsp_pkg::cmd_type      cmd;
      logic [1:0]             player;
      gpsp_pkg::pad_byte_type button_mask;
      logic                   pressed;
      logic                   port;
      logic                   strobe_level;
      logic                   has_known;
      gpsp_pkg::pad_byte_type known_data;
   } pad_stim_row_type;

   logic         clock            = 1'b0;
   logic         reset            = 1'b1;
   logic         req_valid        = 1'b0;
   logic         req_ready;
   logic [1:0]   req_cmd          = gpsp_pkg::CMD_UNUSED;
   logic [1:0]   req_player       = 2'd0;
   logic [7:0]   req_button_mask  = 8'h00;
   logic         req_pressed      = 1'b0;
   logic         req_port         = 1'b0;
   logic         req_strobe_level = 1'b0;
   logic         rsp_valid;
   logic         rsp_ready        = 1'b0;
   logic [7:0]   rsp_read_data;

   logic                   cur_has_known  = 1'b0;
   gpsp_pkg::pad_byte_type cur_known_data = 8'h00;

   gpsp_pkg::pad_byte_type   pad_held [4];
   gpsp_pkg::pad_byte_type   pad_filtered [4];
   gpsp_pkg::port_word_type  port_latch [2];
   gpsp_pkg::shift_word_type serial_shift [2];
   logic                     strobe_on;

   gpsp_pkg::pad_byte_type read_expect_q [$];
   int           error_count    = 0;
   int           items_sent     = 0;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   int           hold_token     = 0;
   int           hold_seen      = 0;
   int           hold_left      = 0;
   int           idle_cycles    = 0;

   pad_stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{gpsp_pkg::CMD_READ,    2'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 8'h40},
      '{gpsp_pkg::CMD_READ,    2'd0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 8'h40},
      '{gpsp_pkg::CMD_STROBE,  2'd0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_READ,    2'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 8'h40},
      '{gpsp_pkg::CMD_BUTTON,  2'd0, 8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_READ,    2'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_BUTTON,  2'd0, 8'h30, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_BUTTON,  2'd2, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_BUTTON,  2'd1, 8'hC0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_READ,    2'd0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_BUTTON,  2'd3, 8'h81, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_BUTTON,  2'd1, 8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_READ,    2'd0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_STROBE,  2'd0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_STROBE,  2'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_READ,    2'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_READ,    2'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_READ,    2'd0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_UNUSED,  2'd3, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_BUTTON,  2'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_STROBE,  2'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_READ,    2'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_READ,    2'd0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
      '{gpsp_pkg::CMD_BUTTON,  2'd3, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}
   };

   game_pad_serial_port_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_player       (req_player),
      .req_button_mask  (req_button_mask),
      .req_pressed      (req_pressed),
      .req_port         (req_port),
      .req_strobe_level (req_strobe_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void clear_pad_state();
      for (int i = 0; i < 4; i++) begin
         pad_held[i]     = 8'h00;
         pad_filtered[i] = 8'h00;
      end
      for (int i = 0; i < 2; i++) begin
         port_latch[i]   = 24'h000000;
         serial_shift[i] = 32'h00000000;
      end
      strobe_on = 1'b0;
   endfunction

   function automatic void predict_pad_port(input gpsp_pkg::cmd_type cmd,
                                            input logic [1:0] player,
                                            input gpsp_pkg::pad_byte_type mask,
                                            input logic pressed, input logic port,
                                            input logic level, output logic has_read,
                                            output gpsp_pkg::pad_byte_type data);
      gpsp_pkg::pad_byte_type  f;
      gpsp_pkg::pad_byte_type  sig;
      gpsp_pkg::port_word_type w;
      has_read = 1'b0;
      data     = 8'h00;
      unique case (cmd)
         gpsp_pkg::CMD_BUTTON: begin
            pad_held[player] = pressed ? (pad_held[player] | mask) : (pad_held[player] & ~mask);
            f = pad_held[player];
            if (f[5] && f[4]) begin
               f[5:4] = 2'b00;
            end
            if (f[7] && f[6]) begin
               f[7:6] = 2'b00;
            end
            if (f != pad_filtered[player]) begin
               sig = player[0] ? gpsp_pkg::SIG_PORT1 : gpsp_pkg::SIG_PORT0;
               w   = port_latch[player[0]];
               port_latch[player[0]] = player[1] ? {sig, f, w[7:0]} : {sig, w[15:8], f};
            end
            pad_filtered[player] = f;
         end
         gpsp_pkg::CMD_READ: begin
            has_read = 1'b1;
            if (strobe_on) begin
               data = gpsp_pkg::READ_BASE | {7'd0, port_latch[port][0]};
            end else begin
               data = gpsp_pkg::READ_BASE | {7'd0, serial_shift[port][0]};
               serial_shift[port] = {1'b1, serial_shift[port][31:1]};
            end
         end
         gpsp_pkg::CMD_STROBE: begin
            if (strobe_on && !level) begin
               serial_shift[0] = {8'h00, port_latch[0]};
               serial_shift[1] = {8'h00, port_latch[1]};
            end
            strobe_on = level;
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin
      logic                   has_read;
      gpsp_pkg::pad_byte_type predicted;
      gpsp_pkg::pad_byte_type wanted;
      if (reset) begin
         clear_pad_state();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (read_expect_q.size() == 0) begin
               $display("%0t: unexpected read_data, expected none, actual %02h",
                        $time, rsp_read_data);
               error_count++;
            end else begin
               wanted = read_expect_q.pop_front();
               if (rsp_read_data !== wanted) begin
                  $display("%0t: read_data mismatch, expected %02h, actual %02h",
                           $time, wanted, rsp_read_data);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_pad_port(gpsp_pkg::cmd_type'(req_cmd), req_player, req_button_mask,
                             req_pressed, req_port, req_strobe_level, has_read, predicted);
            if (has_read) begin
               read_expect_q.push_back(cur_has_known ? cur_known_data : predicted);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input pad_stim_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= row.cmd;
      req_player       <= row.player;
      req_button_mask  <= row.button_mask;
      req_pressed      <= row.pressed;
      req_port         <= row.port;
      req_strobe_level <= row.strobe_level;
      cur_has_known    <= row.has_known;
      cur_known_data   <= row.known_data;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      if (row.cmd != gpsp_pkg::CMD_UNUSED) begin
         items_sent++;
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (read_expect_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic pad_stim_row_type random_row(input gpsp_pkg::cmd_type cmd);
      pad_stim_row_type r;
      r.cmd          = cmd;
      r.player       = 2'($urandom_range(3));
      r.button_mask  = 8'($urandom_range(255));
      r.pressed      = 1'($urandom_range(1));
      r.port         = 1'($urandom_range(1));
      r.strobe_level = 1'($urandom_range(1));
      r.has_known    = 1'b0;
      r.known_data   = 8'h00;
      return r;
   endfunction

   task automatic run_read_sequence();
      pad_stim_row_type row;
      int               n;
      logic             main_port;
      n = $urandom_range(4);
      for (int k = 0; k < n; k++) begin
         row = random_row(gpsp_pkg::CMD_BUTTON);
         case ($urandom_range(3))
            0: row.button_mask = 8'(1 << $urandom_range(7));
            1: row.button_mask = gpsp_pkg::UD_BITS;
            2: row.button_mask = gpsp_pkg::LR_BITS;
            default: begin
            end
         endcase
         send_item(row);
      end
      row = random_row(gpsp_pkg::CMD_STROBE);
      row.strobe_level = 1'b1;
      send_item(row);
      n = $urandom_range(2);
      for (int k = 0; k < n; k++) begin
         send_item(random_row(gpsp_pkg::CMD_READ));
      end
      row = random_row(gpsp_pkg::CMD_STROBE);
      row.strobe_level = 1'b0;
      send_item(row);
      main_port = 1'($urandom_range(1));
      n = $urandom_range(1, 40);
      for (int k = 0; k < n; k++) begin
         row = random_row(gpsp_pkg::CMD_READ);
         row.port = ($urandom_range(9) == 0) ? ~main_port : main_port;
         send_item(row);
      end
   endtask

   initial begin
      int idle_pct [4];
      int stall_pct [4];
      int phase_start;
      idle_pct  = '{0, 49, 0, 29};
      stall_pct = '{0, 0, 49, 29};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_item(directed_rows[i]);
      end
      wait_for_drain();

      hold_token <= hold_token + 1;
      for (int i = 0; i < 10; i++) begin
         send_item(random_row(gpsp_pkg::CMD_READ));
      end
      wait_for_drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = idle_pct[ph];
         recv_stall_pct = stall_pct[ph];
         phase_start    = items_sent;
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            if ($urandom_range(99) < 25) begin
               send_item(random_row(gpsp_pkg::cmd_type'(2'($urandom_range(3)))));
            end else begin
               run_read_sequence();
            end
         end
         wait_for_drain();
      end

      repeat (10) @(posedge clock);
      if (read_expect_q.size() != 0) begin
         $display("%0t: %0d read results never arrived", $time, read_expect_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
